// ----- design/rdse_pkg.sv -----
// shared types, constants and the digit character lookup for the radix digit encoder
package rdse_pkg;

  localparam int VALUE_FIELD_W = 32;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int RADIX_W       = 6;
  localparam int STEP_BITS     = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int OUT_DATA_W    = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // register index, taken from paddr[2]
  localparam logic REG_RADIX    = 1'b0;
  localparam logic REG_NEG_MODE = 1'b1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO        = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LETTER_BASE = 7'd55;  // 'A' minus ten
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT    = 6'd10;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               neg_mode;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    if (d < DECIMAL_LIMIT) begin
      return ASCII_ZERO + {1'b0, d};
    end else begin
      return ASCII_LETTER_BASE + {1'b0, d};
    end
  endfunction

endpackage

// ----- design/rdse_ram.sv -----
// generic single-write single-read ram with registered read data
module rdse_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rdse_fifo.sv -----
// small register queue carrying per-item digit counts from front to back
module rdse_fifo #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- design/rdse_front.sv -----
// front end: accepts values and divides out digits into one bank of the digit ram
module rdse_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rdse_pkg::cfg_t                        cfg,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [rdse_pkg::VALUE_FIELD_W-1:0]    s_tdata,
  output logic                                  wr_en,
  output logic [$clog2(VALUE_WIDTH+1):0]        wr_addr,
  output logic [rdse_pkg::DIGIT_W-1:0]          wr_data,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [$clog2(VALUE_WIDTH+2)-1:0]      q_count
);

  import rdse_pkg::*;

  localparam int NCH = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PW  = NCH * STEP_BITS;
  localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int IW  = $clog2(VALUE_WIDTH + 1);
  localparam int CW  = $clog2(VALUE_WIDTH + 2);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_START = 4'b0010,
    F_DIV   = 4'b0100,
    F_DIGIT = 4'b1000
  } fstate_t;

  fstate_t            state, state_next;
  logic [PW-1:0]      mag, mag_next;
  logic               sgn, sgn_next;
  logic [RADIX_W-1:0] rem, rem_next;
  logic [CIW-1:0]     cidx, cidx_next;
  logic [CW-1:0]      count, count_next;
  logic               wbank, wbank_next;

  logic [VALUE_WIDTH+VALUE_FIELD_W-1:0] in_ext;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   raw_neg;
  logic [VALUE_WIDTH-1:0] raw_mag;
  logic [CIW-1:0]         top;
  logic                   mag_zero;
  logic [STEP_BITS-1:0]   chunk;
  logic [STEP_BITS-1:0]   qchunk;
  logic [RADIX_W-1:0]     part;
  logic [RADIX_W:0]       trial;
  logic [DIGIT_W-1:0]     digit;
  logic                   carry;

  assign in_ext  = {{VALUE_WIDTH{1'b0}}, s_tdata};
  assign raw     = in_ext[VALUE_WIDTH-1:0];
  assign raw_neg = cfg.neg_mode & raw[VALUE_WIDTH-1];
  assign raw_mag = raw_neg ? (~raw + 1'b1) : raw;

  assign mag_zero = (mag == '0);
  assign s_tready = (state == F_IDLE) && !q_full;
  assign q_count  = count;
  assign wr_addr  = {wbank, count[IW-1:0]};

  // highest nonzero byte of the remaining quotient
  always_comb begin
    top = '0;
    for (int i = 0; i < NCH; i++) begin
      if (mag[i*STEP_BITS +: STEP_BITS] != '0) begin
        top = CIW'(i);
      end
    end
  end

  // one byte of long division by the radix
  assign chunk = mag[cidx*STEP_BITS +: STEP_BITS];

  always_comb begin
    part   = rem;
    qchunk = '0;
    trial  = '0;
    for (int b = STEP_BITS - 1; b >= 0; b--) begin
      trial = {part, chunk[b]};
      if (trial >= {1'b0, cfg.radix}) begin
        trial     = trial - {1'b0, cfg.radix};
        qchunk[b] = 1'b1;
      end
      part = trial[RADIX_W-1:0];
    end
  end

  // negative value: remainder kept nonnegative, quotient magnitude steps up by one
  assign carry = sgn && (rem != '0);
  assign digit = carry ? DIGIT_W'(cfg.radix - rem) : DIGIT_W'(rem);

  always_comb begin
    state_next = state;
    mag_next   = mag;
    sgn_next   = sgn;
    rem_next   = rem;
    cidx_next  = cidx;
    count_next = count;
    wbank_next = wbank;
    wr_en      = 1'b0;
    wr_data    = digit;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (s_tvalid && s_tready) begin
          mag_next   = PW'(raw_mag);
          sgn_next   = raw_neg;
          count_next = '0;
          state_next = F_START;
        end
      end
      F_START: begin
        if (mag_zero) begin
          if (count == '0) begin
            // zero writes a single '0'
            wr_en      = 1'b1;
            wr_data    = '0;
            count_next = CW'(1);
          end else begin
            q_push     = 1'b1;
            wbank_next = ~wbank;
            state_next = F_IDLE;
          end
        end else begin
          cidx_next  = top;
          rem_next   = '0;
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        mag_next[cidx*STEP_BITS +: STEP_BITS] = qchunk;
        rem_next = part;
        if (cidx == '0) begin
          state_next = F_DIGIT;
        end else begin
          cidx_next = cidx - 1'b1;
        end
      end
      F_DIGIT: begin
        wr_en      = 1'b1;
        mag_next   = mag + PW'(carry);
        sgn_next   = sgn ? 1'b0 : cfg.neg_mode;
        count_next = count + 1'b1;
        state_next = F_START;
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      mag   <= '0;
      sgn   <= 1'b0;
      count <= '0;
      wbank <= 1'b0;
    end else begin
      state <= state_next;
      mag   <= mag_next;
      sgn   <= sgn_next;
      count <= count_next;
      wbank <= wbank_next;
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    cidx <= cidx_next;
  end

endmodule

// ----- design/rdse_back.sv -----
// back end: reads one bank of digits most significant first and streams characters
module rdse_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  logic [$clog2(VALUE_WIDTH+2)-1:0]   q_count,
  output logic                               q_pop,
  output logic [$clog2(VALUE_WIDTH+1):0]     rd_addr,
  input  logic [rdse_pkg::DIGIT_W-1:0]       rd_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rdse_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);

  import rdse_pkg::*;

  localparam int IW = $clog2(VALUE_WIDTH + 1);
  localparam int CW = $clog2(VALUE_WIDTH + 2);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FETCH = 3'b010,
    B_SHOW  = 3'b100
  } bstate_t;

  bstate_t       state, state_next;
  logic [IW-1:0] cur_idx, cur_idx_next;
  logic          rbank, rbank_next;
  logic [CW-1:0] cnt_m1;
  logic          advance;

  assign cnt_m1   = q_count - CW'(1);
  assign m_tvalid = (state == B_SHOW);
  assign m_tlast  = (cur_idx == '0);
  assign m_tdata  = OUT_DATA_W'(digit_to_char(rd_data));
  assign advance  = (state == B_SHOW) && m_tready;

  always_comb begin
    state_next   = state;
    cur_idx_next = cur_idx;
    rbank_next   = rbank;
    q_pop        = 1'b0;
    rd_addr      = {rbank, cur_idx};
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          cur_idx_next = cnt_m1[IW-1:0];
          state_next   = B_FETCH;
        end
      end
      B_FETCH: begin
        state_next = B_SHOW;
      end
      B_SHOW: begin
        if (advance) begin
          if (cur_idx == '0) begin
            q_pop      = 1'b1;
            rbank_next = ~rbank;
            state_next = B_IDLE;
          end else begin
            // next read goes out now so the char is ready next cycle
            cur_idx_next = cur_idx - 1'b1;
            rd_addr      = {rbank, cur_idx - 1'b1};
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      rbank <= 1'b0;
    end else begin
      state <= state_next;
      rbank <= rbank_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx <= cur_idx_next;
  end

endmodule

// ----- design/radix_digit_string_encoder.sv -----
// top level: config registers, front divider, count queue, digit ram and output streamer
// steps: for each digit the front divides the quotient one byte at a time in F_DIV,
//   then writes the digit in F_DIGIT; the back passes B_IDLE and B_FETCH before B_SHOW
// throughput: the front byte-wide divider sets the rate, one byte of quotient per cycle;
//   the front takes no new value until the last one is queued, nor while the count queue
//   is full; characters leave at one per cycle while m_tready is high
// reset: synchronous; radix 10, plain mode, queue empty, both ends idle; digit ram not cleared
module radix_digit_string_encoder #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // apb config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rdse_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [rdse_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rdse_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rdse_pkg::VALUE_FIELD_W-1:0]   s_tdata,   // [31:0] value
  // output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rdse_pkg::OUT_DATA_W-1:0]      m_tdata,   // [6:0] digit_char, [7] zero
  output logic                                 m_tlast    // last_digit
);

  import rdse_pkg::*;

  localparam int IW    = $clog2(VALUE_WIDTH + 1);
  localparam int CW    = $clog2(VALUE_WIDTH + 2);
  localparam int DEPTH = 2 ** (IW + 1);   // two banks, one per item in flight

  cfg_t               cfg;
  logic               cfg_wr;
  logic               reg_sel;
  logic [RADIX_W-1:0] wr_radix;
  logic [RADIX_W-1:0] radix_clamped;

  logic               wr_en;
  logic [IW:0]        wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic [IW:0]        rd_addr;
  logic [DIGIT_W-1:0] rd_data;

  logic               q_push;
  logic [CW-1:0]      q_din;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  logic [CW-1:0]      q_dout;

  // config registers, written on the apb access cycle
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign reg_sel       = paddr[2];
  assign wr_radix      = pwdata[RADIX_W-1:0];
  assign radix_clamped = (wr_radix < RADIX_MIN) ? RADIX_MIN :
                         (wr_radix > RADIX_MAX) ? RADIX_MAX : wr_radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix    <= RADIX_RESET;
      cfg.neg_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_RADIX:    cfg.radix    <= radix_clamped;
        REG_NEG_MODE: cfg.neg_mode <= pwdata[0];
        default:      cfg          <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RADIX:    prdata = APB_DATA_W'(cfg.radix);
      REG_NEG_MODE: prdata = APB_DATA_W'(cfg.neg_mode);
      default:      prdata = '0;
    endcase
  end

  // front: takes a value, fills a bank with digits least significant first
  rdse_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_count  (q_din)
  );

  // digit counts of finished banks, in order
  rdse_fifo #(
    .WIDTH (CW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  // double-banked digit store
  rdse_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // back: streams a bank most significant digit first
  rdse_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_count  (q_dout),
    .q_pop    (q_pop),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clamping keeps the radix register legal at all times
  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    cfg.radix >= RADIX_MIN && cfg.radix <= RADIX_MAX)
    else $error("radix register out of range");

  // front never finishes a bank while both banks are held
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("count queue overflow");

  // an accepted item keeps the front busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("front ready right after accept");

  // every shown character is a legal digit
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd57) ||
                 (m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd90))
    else $error("digit character out of range");

endmodule
